### rtl/bba_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package bba_pkg;

    localparam int POOL_ORDER = 10;
    localparam int NODE_W     = POOL_ORDER + 1;
    localparam int NODE_DEPTH = 1 << NODE_W;
    localparam int ORD_W      = 4;
    localparam int OFF_W      = 10;
    localparam int SIZE_W     = 11;

    localparam logic [1:0] NODE_ABSENT = 2'd0;
    localparam logic [1:0] NODE_FREE   = 2'd1;
    localparam logic [1:0] NODE_USED   = 2'd2;
    localparam logic [1:0] NODE_SPLIT  = 2'd3;

    localparam logic [1:0] STAT_OK      = 2'd0;
    localparam logic [1:0] STAT_NOSPACE = 2'd1;
    localparam logic [1:0] STAT_BADFREE = 2'd2;
    localparam logic [1:0] STAT_ZERO    = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_A_RD,
        ST_A_CHK,
        ST_SPLIT_A,
        ST_SPLIT_B,
        ST_USE,
        ST_F_RD,
        ST_F_CHK,
        ST_F_MARK,
        ST_M_RD,
        ST_M_CHK,
        ST_M_W1,
        ST_M_W2,
        ST_M_W3,
        ST_RESP
    } state_t;

endpackage

`default_nettype wire

### rtl/buddy_block_allocator.sv
`timescale 1ns / 1ps
`default_nettype none

// Binary buddy allocator over a tree of node states held in a 2-bit-wide RAM with
// 2^(POOL_ORDER+1) entries, walked one node at a time by a small sequencer. After reset
// and after every pool_order write the RAM is swept clear, one entry per cycle, while
// in_stall stays high. An allocation reads and checks each node visited in the
// lowest-address search (ST_A_RD, ST_A_CHK), from the smallest fitting order upward,
// then splits level by level (ST_SPLIT_A, ST_SPLIT_B). The search also visits absent
// nodes, so on a lightly used pool it scans whole rows. A free reads and checks each
// level walked down (ST_F_RD, ST_F_CHK) and passes ST_M_RD, ST_M_CHK and ST_M_W1 to
// ST_M_W3 per merge level. One word is handled at a time; the result waits in an output
// register.

module buddy_block_allocator (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        cfg_write,
    input  wire logic [bba_pkg::ORD_W-1:0]   cfg_data,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire logic                        command,
    input  wire logic [bba_pkg::SIZE_W-1:0]  request_size,
    input  wire logic [bba_pkg::OFF_W-1:0]   free_offset,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output logic [1:0]                       status,
    output logic [bba_pkg::OFF_W-1:0]        offset,
    output logic [bba_pkg::ORD_W-1:0]        block_order
);

    localparam int NW = bba_pkg::NODE_W;
    localparam int OW = bba_pkg::OFF_W;
    localparam int RW = bba_pkg::ORD_W;

    bba_pkg::state_t state_reg, state_next;

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] first_reg, first_next;
    logic [NW-1:0] clr_reg, clr_next;
    logic [RW-1:0] o_reg, o_next;
    logic [RW-1:0] need_reg, need_next;
    logic [RW-1:0] pool_reg, pool_next;
    logic [OW-1:0] off_reg, off_next;
    logic [1:0]    rs_reg, rs_next;
    logic [OW-1:0] ro_reg, ro_next;
    logic [RW-1:0] rd_reg, rd_next;
    logic          out_valid_reg, out_valid_next;
    logic [1:0]    status_reg, status_next;
    logic [OW-1:0] offset_reg, offset_next;
    logic [RW-1:0] order_reg, order_next;

    logic          ram_we;
    logic [NW-1:0] ram_waddr;
    logic [1:0]    ram_wdata;
    logic [NW-1:0] ram_raddr;
    logic [1:0]    ram_rdata;

    logic [RW-1:0]          pool_eff;
    logic [bba_pkg::SIZE_W-1:0] size_m1;
    logic [RW-1:0]          need_c;
    logic [NW:0]            n_inc;
    logic [NW+OW-1:0]       off_wide;
    logic [OW-1:0]          pool_mask;
    logic [OW-1:0]          ord_mask;
    logic [RW-1:0]          o_dec;
    logic [OW-1:0]          off_shift;

    bba_ram #(
        .WIDTH(2),
        .DEPTH(bba_pkg::NODE_DEPTH)
    ) u_ram (
        .clk  (clk),
        .we   (ram_we),
        .waddr(ram_waddr),
        .wdata(ram_wdata),
        .raddr(ram_raddr),
        .rdata(ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= bba_pkg::ST_CLEAR;
            clr_reg       <= '0;
            pool_reg      <= RW'(bba_pkg::POOL_ORDER);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pool_reg      <= pool_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg      <= n_next;
        first_reg  <= first_next;
        o_reg      <= o_next;
        need_reg   <= need_next;
        off_reg    <= off_next;
        rs_reg     <= rs_next;
        ro_reg     <= ro_next;
        rd_reg     <= rd_next;
        status_reg <= status_next;
        offset_reg <= offset_next;
        order_reg  <= order_next;
    end

    always_comb
    begin
        pool_eff = (pool_reg > RW'(bba_pkg::POOL_ORDER)) ? RW'(bba_pkg::POOL_ORDER) : pool_reg;
        size_m1  = request_size - 1'b1;
        need_c   = '0;
        for (int i = 0; i < bba_pkg::SIZE_W; i++)
        begin
            if (size_m1[i])
            begin
                need_c = RW'(i + 1);
            end
        end
        n_inc     = {1'b0, n_reg} + 1'b1;
        off_wide  = {{OW{1'b0}}, n_reg} << need_reg;
        pool_mask = ~({OW{1'b1}} << pool_eff);
        ord_mask  = ~({OW{1'b1}} << o_reg);
        o_dec     = o_reg - 1'b1;
        off_shift = off_reg >> o_dec;
    end

    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        first_next     = first_reg;
        clr_next       = clr_reg;
        o_next         = o_reg;
        need_next      = need_reg;
        pool_next      = pool_reg;
        off_next       = off_reg;
        rs_next        = rs_reg;
        ro_next        = ro_reg;
        rd_next        = rd_reg;
        status_next    = status_reg;
        offset_next    = offset_reg;
        order_next     = order_reg;
        out_valid_next = out_valid_reg && out_stall;
        ram_we         = 1'b0;
        ram_waddr      = n_reg;
        ram_wdata      = bba_pkg::NODE_ABSENT;
        ram_raddr      = n_reg;

        case (state_reg)
            bba_pkg::ST_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = (clr_reg == NW'(1)) ? bba_pkg::NODE_FREE : bba_pkg::NODE_ABSENT;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == {NW{1'b1}})
                begin
                    state_next = bba_pkg::ST_IDLE;
                end
            end
            bba_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    rs_next = bba_pkg::STAT_OK;
                    ro_next = '0;
                    rd_next = '0;
                    if (command == bba_pkg::CMD_ALLOC)
                    begin
                        need_next = need_c;
                        o_next    = need_c;
                        first_next = NW'(1) << (pool_eff - need_c);
                        n_next     = NW'(1) << (pool_eff - need_c);
                        if (request_size == '0)
                        begin
                            rs_next    = bba_pkg::STAT_ZERO;
                            state_next = bba_pkg::ST_RESP;
                        end
                        else if (need_c > pool_eff)
                        begin
                            rs_next    = bba_pkg::STAT_NOSPACE;
                            state_next = bba_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = bba_pkg::ST_A_RD;
                        end
                    end
                    else
                    begin
                        off_next = free_offset;
                        n_next   = NW'(1);
                        o_next   = pool_eff;
                        if ({1'b0, free_offset} >= ((OW+1)'(1) << pool_eff))
                        begin
                            rs_next    = bba_pkg::STAT_BADFREE;
                            state_next = bba_pkg::ST_RESP;
                        end
                        else
                        begin
                            state_next = bba_pkg::ST_F_RD;
                        end
                    end
                end
            end
            bba_pkg::ST_A_RD:
            begin
                state_next = bba_pkg::ST_A_CHK;
            end
            bba_pkg::ST_A_CHK:
            begin
                if (ram_rdata == bba_pkg::NODE_FREE)
                begin
                    state_next = (o_reg > need_reg) ? bba_pkg::ST_SPLIT_A : bba_pkg::ST_USE;
                end
                else if (n_inc == {first_reg, 1'b0})
                begin
                    // Last node of this order; move up one order, its row is half as wide.
                    if (o_reg == pool_eff)
                    begin
                        rs_next    = bba_pkg::STAT_NOSPACE;
                        state_next = bba_pkg::ST_RESP;
                    end
                    else
                    begin
                        o_next     = o_reg + 1'b1;
                        first_next = first_reg >> 1;
                        n_next     = first_reg >> 1;
                        state_next = bba_pkg::ST_A_RD;
                    end
                end
                else
                begin
                    n_next     = n_inc[NW-1:0];
                    state_next = bba_pkg::ST_A_RD;
                end
            end
            bba_pkg::ST_SPLIT_A:
            begin
                ram_we     = 1'b1;
                ram_wdata  = bba_pkg::NODE_SPLIT;
                state_next = bba_pkg::ST_SPLIT_B;
            end
            bba_pkg::ST_SPLIT_B:
            begin
                ram_we     = 1'b1;
                ram_waddr  = {n_reg[NW-2:0], 1'b1};
                ram_wdata  = bba_pkg::NODE_FREE;
                n_next     = {n_reg[NW-2:0], 1'b0};
                o_next     = o_dec;
                state_next = (o_dec > need_reg) ? bba_pkg::ST_SPLIT_A : bba_pkg::ST_USE;
            end
            bba_pkg::ST_USE:
            begin
                ram_we     = 1'b1;
                ram_wdata  = bba_pkg::NODE_USED;
                rs_next    = bba_pkg::STAT_OK;
                ro_next    = off_wide[OW-1:0] & pool_mask;
                rd_next    = need_reg;
                state_next = bba_pkg::ST_RESP;
            end
            bba_pkg::ST_F_RD:
            begin
                state_next = bba_pkg::ST_F_CHK;
            end
            bba_pkg::ST_F_CHK:
            begin
                if (ram_rdata == bba_pkg::NODE_SPLIT && o_reg != '0)
                begin
                    o_next     = o_dec;
                    n_next     = {n_reg[NW-2:0], off_shift[0]};
                    state_next = bba_pkg::ST_F_RD;
                end
                else if (ram_rdata == bba_pkg::NODE_USED && (off_reg & ord_mask) == '0)
                begin
                    rs_next    = bba_pkg::STAT_OK;
                    ro_next    = off_reg;
                    rd_next    = o_reg;
                    state_next = bba_pkg::ST_F_MARK;
                end
                else
                begin
                    rs_next    = bba_pkg::STAT_BADFREE;
                    state_next = bba_pkg::ST_RESP;
                end
            end
            bba_pkg::ST_F_MARK:
            begin
                ram_we     = 1'b1;
                ram_wdata  = bba_pkg::NODE_FREE;
                state_next = bba_pkg::ST_M_RD;
            end
            bba_pkg::ST_M_RD:
            begin
                ram_raddr  = n_reg ^ NW'(1);
                state_next = (n_reg == NW'(1)) ? bba_pkg::ST_RESP : bba_pkg::ST_M_CHK;
            end
            bba_pkg::ST_M_CHK:
            begin
                state_next = (ram_rdata == bba_pkg::NODE_FREE) ? bba_pkg::ST_M_W1
                                                               : bba_pkg::ST_RESP;
            end
            bba_pkg::ST_M_W1:
            begin
                ram_we     = 1'b1;
                ram_wdata  = bba_pkg::NODE_ABSENT;
                state_next = bba_pkg::ST_M_W2;
            end
            bba_pkg::ST_M_W2:
            begin
                ram_we     = 1'b1;
                ram_waddr  = n_reg ^ NW'(1);
                ram_wdata  = bba_pkg::NODE_ABSENT;
                state_next = bba_pkg::ST_M_W3;
            end
            bba_pkg::ST_M_W3:
            begin
                ram_we     = 1'b1;
                ram_waddr  = n_reg >> 1;
                ram_wdata  = bba_pkg::NODE_FREE;
                n_next     = n_reg >> 1;
                state_next = bba_pkg::ST_M_RD;
            end
            bba_pkg::ST_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next = 1'b1;
                    status_next    = rs_reg;
                    offset_next    = ro_reg;
                    order_next     = rd_reg;
                    state_next     = bba_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = bba_pkg::ST_IDLE;
            end
        endcase

        if (cfg_write)
        begin
            pool_next  = cfg_data;
            clr_next   = '0;
            state_next = bba_pkg::ST_CLEAR;
        end
    end

    assign in_stall    = (state_reg != bba_pkg::ST_IDLE);
    assign out_valid   = out_valid_reg;
    assign status      = status_reg;
    assign offset      = offset_reg;
    assign block_order = order_reg;

    a_accept_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> state_reg == bba_pkg::ST_IDLE)
        else $error("input taken outside idle");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bba_pkg::ST_IDLE |-> !ram_we)
        else $error("node RAM written while idle");

    a_aligned: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == bba_pkg::STAT_OK |->
            (offset & ~({OW{1'b1}} << block_order)) == '0)
        else $error("granted block not aligned to its order");

    a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != bba_pkg::STAT_OK |-> offset == '0 && block_order == '0)
        else $error("error word carries nonzero fields");

    a_clear_done: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == bba_pkg::ST_CLEAR && !cfg_write && clr_reg != {NW{1'b1}}
            |=> state_reg == bba_pkg::ST_CLEAR)
        else $error("clearing sweep cut short");

endmodule

`default_nettype wire

### rtl/bba_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module bba_ram #(
    parameter int WIDTH = 2,
    parameter int DEPTH = 2048
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

### verif/buddy_block_allocator_tb.sv
`timescale 1ns / 1ps

module buddy_block_allocator_tb;

    localparam logic CMD_RELEASE  = ~bba_pkg::CMD_ALLOC;
    localparam int   CYCLE_LIMIT  = 25000000;
    localparam int   CALM_TAIL    = 150;
    localparam int   HOLD_AT      = 300;
    localparam int   HOLD_CYCLES  = 400;
    localparam int   DRAIN_CYCLES = 100;

    typedef struct {
        bit                         is_cfg;
        logic [bba_pkg::ORD_W-1:0]  cfg_value;
        logic                       cmd;
        logic [bba_pkg::SIZE_W-1:0] size;
        logic [bba_pkg::OFF_W-1:0]  off;
        logic [1:0]                 exp_status;
        logic [bba_pkg::OFF_W-1:0]  exp_off;
        logic [bba_pkg::ORD_W-1:0]  exp_ord;
    } request_t;

    typedef struct {
        logic [1:0]                status;
        logic [bba_pkg::OFF_W-1:0] off;
        logic [bba_pkg::ORD_W-1:0] ord;
    } grant_t;

    logic                       clk;
    logic                       rst_n;
    logic                       cfg_write;
    logic [bba_pkg::ORD_W-1:0]  cfg_data;
    logic                       in_valid;
    logic                       in_stall;
    logic                       command;
    logic [bba_pkg::SIZE_W-1:0] request_size;
    logic [bba_pkg::OFF_W-1:0]  free_offset;
    logic                       out_valid;
    logic                       out_stall;
    logic [1:0]                 status;
    logic [bba_pkg::OFF_W-1:0]  offset;
    logic [bba_pkg::ORD_W-1:0]  block_order;

    // Shadow of the allocation tree, heap-indexed from 1.
    logic [1:0]                 tree [bba_pkg::NODE_DEPTH];
    logic [bba_pkg::ORD_W-1:0]  pool_setting;

    request_t                   pending_q[$];
    grant_t                     grant_q[$];
    logic [bba_pkg::OFF_W-1:0]  held_offsets[$];
    int                         total_words;
    int                         sent_words;
    int                         errors = 0;
    int                         cycles = 0;
    int                         send_gap;
    int                         recv_gap;
    int                         hold_left;
    bit                         hold_done;

    buddy_block_allocator dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_data     (cfg_data),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .command      (command),
        .request_size (request_size),
        .free_offset  (free_offset),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .status       (status),
        .offset       (offset),
        .block_order  (block_order)
    );

    function automatic int pool_levels();
        return (pool_setting > bba_pkg::POOL_ORDER) ? bba_pkg::POOL_ORDER : int'(pool_setting);
    endfunction

    function automatic void clear_tree();
        foreach (tree[i])
            tree[i] = bba_pkg::NODE_ABSENT;
        tree[1] = bba_pkg::NODE_FREE;
    endfunction

    function automatic grant_t grant_block(input logic [bba_pkg::SIZE_W-1:0] size);
        grant_t g;
        int     pool;
        int     need;
        int     first;
        int     cur;
        int     co;
        pool = pool_levels();
        need = 0;
        g = '{bba_pkg::STAT_NOSPACE, '0, '0};
        if (size == 0) begin
            g.status = bba_pkg::STAT_ZERO;
            return g;
        end
        while (need < 12 && (1 << need) < size)
            need++;
        if (need > pool)
            return g;
        for (int o = need; o <= pool; o++) begin
            first = 1 << (pool - o);
            for (int n = first; n < 2 * first; n++) begin
                if (tree[n] == bba_pkg::NODE_FREE) begin
                    cur = n;
                    co = o;
                    while (co > need) begin
                        tree[cur] = bba_pkg::NODE_SPLIT;
                        tree[2 * cur + 1] = bba_pkg::NODE_FREE;
                        cur = 2 * cur;
                        co--;
                    end
                    tree[cur] = bba_pkg::NODE_USED;
                    g.status = bba_pkg::STAT_OK;
                    g.off = bba_pkg::OFF_W'((cur - (1 << (pool - need))) << need);
                    g.ord = bba_pkg::ORD_W'(need);
                    return g;
                end
            end
        end
        return g;
    endfunction

    function automatic grant_t release_block(input logic [bba_pkg::OFF_W-1:0] off);
        grant_t g;
        int     pool;
        int     n;
        int     ord;
        pool = pool_levels();
        n = 1;
        ord = pool;
        g = '{bba_pkg::STAT_BADFREE, '0, '0};
        if (int'(off) >= (1 << pool))
            return g;
        while (tree[n] == bba_pkg::NODE_SPLIT && ord > 0) begin
            ord--;
            n = 2 * n + ((off >> ord) & 1);
        end
        if (tree[n] != bba_pkg::NODE_USED || (int'(off) & ((1 << ord) - 1)) != 0)
            return g;
        g = '{bba_pkg::STAT_OK, off, bba_pkg::ORD_W'(ord)};
        tree[n] = bba_pkg::NODE_FREE;
        // Merge upward while the buddy is also free.
        while (n > 1 && tree[n ^ 1] == bba_pkg::NODE_FREE) begin
            tree[n] = bba_pkg::NODE_ABSENT;
            tree[n ^ 1] = bba_pkg::NODE_ABSENT;
            n = n >> 1;
            tree[n] = bba_pkg::NODE_FREE;
        end
        return g;
    endfunction

    function automatic void add_request(input logic cmd, input int size, input int off);
        request_t r;
        grant_t   g;
        r.is_cfg = 0;
        r.cfg_value = '0;
        r.cmd = cmd;
        r.size = bba_pkg::SIZE_W'(size);
        r.off = bba_pkg::OFF_W'(off);
        g = (cmd == bba_pkg::CMD_ALLOC) ? grant_block(r.size) : release_block(r.off);
        r.exp_status = g.status;
        r.exp_off = g.off;
        r.exp_ord = g.ord;
        if (g.status == bba_pkg::STAT_OK) begin
            if (cmd == bba_pkg::CMD_ALLOC)
                held_offsets.insert(held_offsets.size(), g.off);
            else
                foreach (held_offsets[i])
                    if (held_offsets[i] == g.off) begin
                        held_offsets.delete(i);
                        break;
                    end
        end
        pending_q.insert(pending_q.size(), r);
        total_words++;
    endfunction

    function automatic void add_setting(input logic [bba_pkg::ORD_W-1:0] value);
        request_t r;
        r = '{1, value, bba_pkg::CMD_ALLOC, '0, '0, '0, '0, '0};
        pending_q.insert(pending_q.size(), r);
        pool_setting = value;
        clear_tree();
        held_offsets.delete();
    endfunction

    function automatic void add_random_request();
        int pick;
        int pool;
        pool = pool_levels();
        pick = $urandom_range(0, 99);
        if (pick < 5)
            add_request(bba_pkg::CMD_ALLOC, 0, $urandom_range(0, 1023));
        else if (pick < 10)
            add_request(bba_pkg::CMD_ALLOC, $urandom_range(0, 1024), $urandom_range(0, 1023));
        else if (pick < 60)
            add_request(bba_pkg::CMD_ALLOC, $urandom_range(1, 1 << $urandom_range(0, pool)),
                        $urandom_range(0, 1023));
        else if (pick < 90 && held_offsets.size() > 0)
            add_request(CMD_RELEASE, $urandom_range(0, 2047),
                        held_offsets[$urandom_range(0, held_offsets.size() - 1)]);
        else
            add_request(CMD_RELEASE, $urandom_range(0, 2047), $urandom_range(0, 1023));
    endfunction

    initial begin
        clk = 0;
        forever #6 clk = ~clk;
    end

    initial begin
        logic [bba_pkg::ORD_W-1:0] settings [10];
        settings = '{4'd15, 4'd0, 4'd1, 4'd3, 4'd6, 4'd10, 4'd4, 4'd2, 4'd9, 4'd5};
        total_words = 0;
        pool_setting = bba_pkg::POOL_ORDER;
        clear_tree();

        // Directed words on the full pool after reset.
        add_request(bba_pkg::CMD_ALLOC, 0, 0);
        add_request(bba_pkg::CMD_ALLOC, 1024, 0);
        add_request(bba_pkg::CMD_ALLOC, 1, 0);
        add_request(CMD_RELEASE, 0, 1);
        add_request(CMD_RELEASE, 2047, 0);
        add_request(CMD_RELEASE, 0, 0);
        add_request(bba_pkg::CMD_ALLOC, 1, 1023);
        add_request(bba_pkg::CMD_ALLOC, 3, 0);
        add_request(bba_pkg::CMD_ALLOC, 2, 0);
        add_request(bba_pkg::CMD_ALLOC, 513, 0);
        add_request(CMD_RELEASE, 0, 0);
        add_request(CMD_RELEASE, 0, 4);
        add_request(CMD_RELEASE, 0, 2);
        add_request(CMD_RELEASE, 0, 1023);
        add_request(bba_pkg::CMD_ALLOC, 1024, 0);
        add_request(CMD_RELEASE, 0, 0);
        add_request(bba_pkg::CMD_ALLOC, 1023, 0);
        add_request(CMD_RELEASE, 0, 0);

        foreach (settings[p]) begin
            add_setting(settings[p]);
            // A tiny pool: frees past its end and sizes above it.
            if (p == 1) begin
                add_request(bba_pkg::CMD_ALLOC, 2, 0);
                add_request(bba_pkg::CMD_ALLOC, 1, 0);
                add_request(CMD_RELEASE, 0, 1);
                add_request(CMD_RELEASE, 0, 0);
            end
            repeat (113)
                add_random_request();
        end
    end

    initial begin
        rst_n = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
    end

    // Sender: holds each word until it is taken, writes the register only when idle.
    always @(posedge clk or negedge rst_n) begin
        bit     fire;
        bit     cfg_pulse;
        grant_t exp;
        if (!rst_n) begin
            in_valid     <= 0;
            cfg_write    <= 0;
            cfg_data     <= '0;
            command      <= bba_pkg::CMD_ALLOC;
            request_size <= '0;
            free_offset  <= '0;
            send_gap     <= 0;
            sent_words   <= 0;
        end else begin
            fire = in_valid && !in_stall;
            cfg_pulse = 0;
            if (fire) begin
                exp = '{pending_q[0].exp_status, pending_q[0].exp_off, pending_q[0].exp_ord};
                grant_q.insert(grant_q.size(), exp);
                void'(pending_q.pop_front());
                sent_words <= sent_words + 1;
            end
            if (in_valid && !fire) begin
                // Word is stalled: keep it as is.
            end else if (send_gap > 0) begin
                in_valid <= 0;
                send_gap <= send_gap - 1;
            end else if (pending_q.size() == 0) begin
                in_valid <= 0;
            end else if (pending_q[0].is_cfg) begin
                in_valid <= 0;
                if (grant_q.size() == 0 && !cfg_write) begin
                    cfg_pulse = 1;
                    cfg_data  <= pending_q[0].cfg_value;
                    void'(pending_q.pop_front());
                end
            end else if (sent_words < total_words - CALM_TAIL &&
                         $urandom_range(0, 9) == 0) begin
                in_valid <= 0;
                send_gap <= $urandom_range(0, 12);
            end else begin
                in_valid     <= 1;
                command      <= pending_q[0].cmd;
                request_size <= pending_q[0].size;
                free_offset  <= pending_q[0].off;
            end
            cfg_write <= cfg_pulse;
        end
    end

    // Receiver back-pressure, with one long hold-off partway through.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            out_stall <= 0;
            recv_gap  <= 0;
            hold_left <= 0;
            hold_done <= 0;
        end else if (hold_left > 0) begin
            out_stall <= 1;
            hold_left <= hold_left - 1;
        end else if (!hold_done && sent_words >= HOLD_AT) begin
            out_stall <= 1;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1;
        end else if (recv_gap > 0) begin
            out_stall <= 1;
            recv_gap  <= recv_gap - 1;
        end else if (sent_words < total_words - CALM_TAIL && $urandom_range(0, 9) == 0) begin
            out_stall <= 1;
            recv_gap  <= $urandom_range(0, 12);
        end else begin
            out_stall <= 0;
        end
    end

    always @(posedge clk) begin
        grant_t g;
        if (rst_n && out_valid && !out_stall) begin
            if (grant_q.size() == 0) begin
                $error("result word with nothing expected: status %0d offset %0d order %0d",
                       status, offset, block_order);
                errors++;
            end else begin
                g = grant_q.pop_front();
                if (status !== g.status) begin
                    $error("status: expected %0d, got %0d", g.status, status);
                    errors++;
                end
                if (offset !== g.off) begin
                    $error("offset: expected %0d, got %0d", g.off, offset);
                    errors++;
                end
                if (block_order !== g.ord) begin
                    $error("block_order: expected %0d, got %0d", g.ord, block_order);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial begin
        @(posedge rst_n);
        @(posedge clk);
        wait (pending_q.size() == 0 && grant_q.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0 && grant_q.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

### sim.f
rtl/bba_pkg.sv
rtl/bba_ram.sv
rtl/buddy_block_allocator.sv
verif/buddy_block_allocator_tb.sv
